### rtl/core/sitt_pkg.sv
// Shared types, codes and constants of the shared interval tick timer.
package sitt_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CH_W     = 6;
  localparam int unsigned IVMS_W   = 10;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TICK_W   = 32;

  // Parameter defaults
  localparam int unsigned DEF_MAX_INTERVAL = 1000;
  localparam int unsigned DEF_NUM_CHANNELS = 64;

  // Front-end queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // Tick wraps back to zero when it reaches this value
  localparam logic [TICK_W-1:0] TICK_WRAP = 32'hFFFF_FBFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_DUE   = 2'd2;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_TICK,
    OP_INIT,
    OP_STEP,
    OP_CHECK,
    OP_DESTROY,
    OP_NOP
  } op_e;

  // Classified item as queued between front and back
  typedef struct packed {
    op_e               op;
    logic              ch_ok;
    logic              iv_ok;
    logic [CH_W-1:0]   ch;
    logic [IVMS_W-1:0] iv;
    logic [SMP_W-1:0]  smp;
  } item_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_WALK,
    BK_IV_RD,
    BK_EXEC,
    BK_ATTACH_RD,
    BK_ATTACH,
    BK_MUL,
    BK_FIN
  } bk_state_e;

endpackage

### rtl/core/sitt_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
module sitt_front #(
  parameter int unsigned MAX_INTERVAL = sitt_pkg::DEF_MAX_INTERVAL,
  parameter int unsigned NUM_CHANNELS = sitt_pkg::DEF_NUM_CHANNELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sitt_pkg::CMD_W-1:0]   command_i,
  input  logic [sitt_pkg::CH_W-1:0]    channel_id_i,
  input  logic [sitt_pkg::IVMS_W-1:0]  interval_ms_i,
  input  logic [sitt_pkg::SMP_W-1:0]   samples_per_tick_i,
  input  logic                         clearing_i,
  output logic                         busy_o,
  output logic                         q_valid_o,
  output sitt_pkg::item_t              q_item_o,
  input  logic                         pop_i
);

  localparam int unsigned QD  = sitt_pkg::QUEUE_DEPTH;
  localparam int unsigned PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CNW = $clog2(QD + 1);

  sitt_pkg::item_t     item;
  sitt_pkg::item_t     q_mem_q [QD];
  logic [PW-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNW-1:0]      cnt_q, cnt_d;
  logic                push;

  // Classify the incoming command
  always_comb begin
    case (command_i)
      sitt_pkg::CMD_TICK:    item.op = sitt_pkg::OP_TICK;
      sitt_pkg::CMD_INIT:    item.op = sitt_pkg::OP_INIT;
      sitt_pkg::CMD_STEP:    item.op = sitt_pkg::OP_STEP;
      sitt_pkg::CMD_CHECK:   item.op = sitt_pkg::OP_CHECK;
      sitt_pkg::CMD_DESTROY: item.op = sitt_pkg::OP_DESTROY;
      default:               item.op = sitt_pkg::OP_NOP;
    endcase
    item.ch_ok = 32'(channel_id_i) < 32'(NUM_CHANNELS);
    item.iv_ok = (interval_ms_i != '0) && (32'(interval_ms_i) < 32'(MAX_INTERVAL));
    item.ch    = channel_id_i;
    item.iv    = interval_ms_i;
    item.smp   = samples_per_tick_i;
  end

  assign busy_o    = (cnt_q == CNW'(QD)) || clearing_i;
  assign push      = start_i && !busy_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = q_mem_q[rptr_q];

  // Queue pointers
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(QD - 1)) ? '0 : PW'(wptr_q + 1'b1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(QD - 1)) ? '0 : PW'(rptr_q + 1'b1);
    end
    if (push && !pop_i) begin
      cnt_d = CNW'(cnt_q + 1'b1);
    end else if (!push && pop_i) begin
      cnt_d = CNW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= item;
    end
  end

endmodule

### rtl/core/sitt_back.sv
// Back end: interval and channel tables, tick walk and channel command sequencer.
module sitt_back #(
  parameter int unsigned MAX_INTERVAL = sitt_pkg::DEF_MAX_INTERVAL,
  parameter int unsigned NUM_CHANNELS = sitt_pkg::DEF_NUM_CHANNELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  sitt_pkg::item_t               q_item_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          done_o,
  output logic [sitt_pkg::STATUS_W-1:0] status_o,
  output logic [sitt_pkg::COUNT_W-1:0]  sample_count_o,
  output logic                          stepped_o
);

  localparam int unsigned IW  = $clog2(MAX_INTERVAL);
  localparam int unsigned CW  = $clog2(MAX_INTERVAL + 1);
  localparam int unsigned UW  = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned CAW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned TW  = sitt_pkg::TICK_W;
  localparam int unsigned SW  = sitt_pkg::SMP_W;
  localparam int unsigned PRW = TW + SW;

  // Interval table
  logic [TW-1:0] iv_tick_mem  [MAX_INTERVAL];
  logic [TW-1:0] iv_roll_mem  [MAX_INTERVAL];
  logic [UW-1:0] iv_users_mem [MAX_INTERVAL];
  logic [IW-1:0] iv_rem_mem   [MAX_INTERVAL];
  logic [IW-1:0] iv_raddr, iv_waddr;
  logic          iv_we;
  logic [TW-1:0] iv_wtick, iv_wroll;
  logic [UW-1:0] iv_wusers;
  logic [IW-1:0] iv_wrem;
  logic [TW-1:0] iv_tick_rd_q, iv_roll_rd_q;
  logic [UW-1:0] iv_users_rd_q;
  logic [IW-1:0] iv_rem_rd_q;

  // Channel table
  logic [TW-1:0]  ch_ref_mem   [NUM_CHANNELS];
  logic [TW-1:0]  ch_start_mem [NUM_CHANNELS];
  logic [TW-1:0]  ch_roll_mem  [NUM_CHANNELS];
  logic [IW-1:0]  ch_iv_mem    [NUM_CHANNELS];
  logic [SW-1:0]  ch_smp_mem   [NUM_CHANNELS];
  logic [CAW-1:0] ch_raddr, ch_waddr;
  logic           ch_we;
  logic [TW-1:0]  ch_wref, ch_wstart, ch_wroll;
  logic [IW-1:0]  ch_wiv;
  logic [SW-1:0]  ch_wsmp;
  logic [TW-1:0]  ch_ref_rd_q, ch_start_rd_q, ch_roll_rd_q;
  logic [IW-1:0]  ch_iv_rd_q;
  logic [SW-1:0]  ch_smp_rd_q;

  // Control and working registers
  sitt_pkg::bk_state_e   st_q, st_d;
  sitt_pkg::item_t       item_q, item_d;
  logic [NUM_CHANNELS-1:0] ready_q, ready_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [IW-1:0]         pwa_q, pwa_d;
  logic [IW-1:0]         phase_q, phase_d;
  logic [TW-1:0]         ref_q, ref_d, start_q, start_d, roll_q, roll_d, diff_q, diff_d;
  logic [IW-1:0]         civ_q, civ_d;
  logic [SW-1:0]         smp_q, smp_d;
  logic [PRW-1:0]        prod_q, prod_d;
  logic                  done_q, done_d, stepped_q, stepped_d;
  logic [sitt_pkg::STATUS_W-1:0] status_q, status_d;
  logic [sitt_pkg::COUNT_W-1:0]  count_q, count_d;

  // Scratch values of the combinational block
  logic [CAW-1:0] q_ch, it_ch;
  logic           q_rdy, wrap;
  logic [IW-1:0]  rem_n;
  logic [TW-1:0]  tick_inc, ref_n, start_n, roll_n;
  logic [UW-1:0]  users_n;

  assign q_ch       = CAW'(q_item_i.ch);
  assign it_ch      = CAW'(item_q.ch);
  assign q_rdy      = q_item_i.ch_ok && ready_q[q_ch];
  assign wrap       = (CW'(phase_q) + 1'b1) == CW'(MAX_INTERVAL);
  assign clearing_o = (st_q == sitt_pkg::BK_CLEAR);

  // Sequencer
  always_comb begin
    st_d      = st_q;
    item_d    = item_q;
    ready_d   = ready_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    pwa_d     = pwa_q;
    phase_d   = phase_q;
    ref_d     = ref_q;
    start_d   = start_q;
    roll_d    = roll_q;
    diff_d    = diff_q;
    civ_d     = civ_q;
    smp_d     = smp_q;
    prod_d    = prod_q;
    done_d    = 1'b0;
    status_d  = status_q;
    count_d   = count_q;
    stepped_d = stepped_q;
    pop_o     = 1'b0;

    iv_raddr  = '0;
    iv_we     = 1'b0;
    iv_waddr  = '0;
    iv_wtick  = iv_tick_rd_q;
    iv_wroll  = iv_roll_rd_q;
    iv_wusers = iv_users_rd_q;
    iv_wrem   = iv_rem_rd_q;

    ch_raddr  = (st_q == sitt_pkg::BK_IDLE) ? q_ch : it_ch;
    ch_we     = 1'b0;
    ch_waddr  = it_ch;
    ch_wref   = ref_q;
    ch_wstart = start_q;
    ch_wroll  = roll_q;
    ch_wiv    = civ_q;
    ch_wsmp   = smp_q;

    rem_n     = '0;
    tick_inc  = iv_tick_rd_q + 1'b1;
    ref_n     = ref_q;
    start_n   = start_q;
    roll_n    = roll_q;
    users_n   = (iv_users_rd_q != '0) ? UW'(iv_users_rd_q - 1'b1) : '0;

    case (st_q)
      // Zero the interval table after reset
      sitt_pkg::BK_CLEAR: begin
        if (cnt_q == CW'(MAX_INTERVAL)) begin
          st_d = sitt_pkg::BK_IDLE;
        end else begin
          iv_we     = 1'b1;
          iv_waddr  = cnt_q[IW-1:0];
          iv_wtick  = '0;
          iv_wroll  = '0;
          iv_wusers = '0;
          iv_wrem   = '0;
          cnt_d     = CW'(cnt_q + 1'b1);
        end
      end

      // Take the next item and dispatch it
      sitt_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          item_d    = q_item_i;
          status_d  = sitt_pkg::ST_OK;
          count_d   = '0;
          stepped_d = 1'b0;
          case (q_item_i.op)
            sitt_pkg::OP_TICK: begin
              cnt_d  = CW'(1);
              pend_d = 1'b0;
              st_d   = sitt_pkg::BK_WALK;
            end
            sitt_pkg::OP_INIT: begin
              if (!q_item_i.ch_ok || !q_item_i.iv_ok) begin
                status_d = sitt_pkg::ST_NOT_READY;
                done_d   = 1'b1;
              end else if (q_rdy) begin
                st_d = sitt_pkg::BK_IV_RD;
              end else begin
                st_d = sitt_pkg::BK_ATTACH_RD;
              end
            end
            sitt_pkg::OP_STEP, sitt_pkg::OP_DESTROY: begin
              if (!q_rdy) begin
                status_d = sitt_pkg::ST_NOT_READY;
                done_d   = 1'b1;
              end else begin
                st_d = sitt_pkg::BK_IV_RD;
              end
            end
            sitt_pkg::OP_CHECK: begin
              if (!q_rdy) begin
                done_d = 1'b1;
              end else begin
                st_d = sitt_pkg::BK_IV_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Walk all intervals, one entry per cycle
      sitt_pkg::BK_WALK: begin
        if (cnt_q < CW'(MAX_INTERVAL)) begin
          iv_raddr = cnt_q[IW-1:0];
          pend_d   = 1'b1;
          pwa_d    = cnt_q[IW-1:0];
          cnt_d    = CW'(cnt_q + 1'b1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          rem_n    = (IW'(iv_rem_rd_q + 1'b1) == pwa_q) ? '0 : IW'(iv_rem_rd_q + 1'b1);
          iv_we    = 1'b1;
          iv_waddr = pwa_q;
          iv_wrem  = wrap ? '0 : rem_n;
          if ((iv_users_rd_q != '0) && (rem_n == '0)) begin
            if (tick_inc == sitt_pkg::TICK_WRAP) begin
              iv_wtick = '0;
              iv_wroll = iv_roll_rd_q + 1'b1;
            end else begin
              iv_wtick = tick_inc;
            end
          end
        end else if (cnt_q == CW'(MAX_INTERVAL)) begin
          phase_d = wrap ? '0 : IW'(phase_q + 1'b1);
          done_d  = 1'b1;
          st_d    = sitt_pkg::BK_IDLE;
        end
      end

      // Channel entry is out; fetch its interval
      sitt_pkg::BK_IV_RD: begin
        ref_d    = ch_ref_rd_q;
        start_d  = ch_start_rd_q;
        roll_d   = ch_roll_rd_q;
        civ_d    = ch_iv_rd_q;
        smp_d    = ch_smp_rd_q;
        iv_raddr = ch_iv_rd_q;
        st_d     = sitt_pkg::BK_EXEC;
      end

      // Detach, or roll catch-up and due check
      sitt_pkg::BK_EXEC: begin
        if (item_q.op == sitt_pkg::OP_INIT || item_q.op == sitt_pkg::OP_DESTROY) begin
          iv_we     = 1'b1;
          iv_waddr  = civ_q;
          iv_wusers = users_n;
          iv_wtick  = (users_n == '0) ? '0 : iv_tick_rd_q;
          ready_d[it_ch] = 1'b0;
          if (item_q.op == sitt_pkg::OP_INIT) begin
            st_d = sitt_pkg::BK_ATTACH_RD;
          end else begin
            done_d = 1'b1;
            st_d   = sitt_pkg::BK_IDLE;
          end
        end else begin
          if (roll_q < iv_roll_rd_q) begin
            roll_n  = roll_q + 1'b1;
            ref_n   = iv_tick_rd_q;
            start_n = iv_tick_rd_q;
          end
          ref_d   = ref_n;
          start_d = start_n;
          roll_d  = roll_n;
          diff_d  = ref_n - start_n;
          if (item_q.op == sitt_pkg::OP_CHECK && iv_tick_rd_q < ref_n) begin
            ch_we     = 1'b1;
            ch_wref   = ref_n;
            ch_wstart = start_n;
            ch_wroll  = roll_n;
            status_d  = sitt_pkg::ST_NOT_DUE;
            done_d    = 1'b1;
            st_d      = sitt_pkg::BK_IDLE;
          end else begin
            // A due check catches up once more before the step
            if (item_q.op == sitt_pkg::OP_CHECK && roll_n < iv_roll_rd_q) begin
              roll_d = roll_n + 1'b1;
            end
            st_d = sitt_pkg::BK_MUL;
          end
        end
      end

      // Fetch the interval the channel attaches to
      sitt_pkg::BK_ATTACH_RD: begin
        iv_raddr = IW'(item_q.iv);
        st_d     = sitt_pkg::BK_ATTACH;
      end

      // Attach the channel
      sitt_pkg::BK_ATTACH: begin
        iv_we     = 1'b1;
        iv_waddr  = IW'(item_q.iv);
        iv_wusers = UW'(iv_users_rd_q + 1'b1);
        ch_we     = 1'b1;
        ch_wref   = iv_tick_rd_q;
        ch_wstart = iv_tick_rd_q;
        ch_wroll  = iv_roll_rd_q;
        ch_wiv    = IW'(item_q.iv);
        ch_wsmp   = item_q.smp;
        ready_d[it_ch] = 1'b1;
        done_d    = 1'b1;
        st_d      = sitt_pkg::BK_IDLE;
      end

      // Samples times elapsed ticks
      sitt_pkg::BK_MUL: begin
        prod_d = PRW'(smp_q) * PRW'(diff_q);
        st_d   = sitt_pkg::BK_FIN;
      end

      // Overflow fallback, reference advance, write back
      sitt_pkg::BK_FIN: begin
        ch_we   = 1'b1;
        ch_wref = ref_q + 1'b1;
        if (prod_q[PRW-1:TW] != '0) begin
          ch_wstart = ref_q;
          count_d   = sitt_pkg::COUNT_W'(smp_q);
        end else begin
          count_d   = prod_q[TW-1:0];
        end
        stepped_d = 1'b1;
        done_d    = 1'b1;
        st_d      = sitt_pkg::BK_IDLE;
      end

      default: begin
        st_d = sitt_pkg::BK_IDLE;
      end
    endcase
  end

  // State register and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sitt_pkg::BK_CLEAR;
      ready_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      phase_q <= '0;
      done_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      ready_q <= ready_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    pwa_q     <= pwa_d;
    ref_q     <= ref_d;
    start_q   <= start_d;
    roll_q    <= roll_d;
    diff_q    <= diff_d;
    civ_q     <= civ_d;
    smp_q     <= smp_d;
    prod_q    <= prod_d;
    status_q  <= status_d;
    count_q   <= count_d;
    stepped_q <= stepped_d;
  end

  // Interval table port
  always_ff @(posedge clk_i) begin
    if (iv_we) begin
      iv_tick_mem[iv_waddr]  <= iv_wtick;
      iv_roll_mem[iv_waddr]  <= iv_wroll;
      iv_users_mem[iv_waddr] <= iv_wusers;
      iv_rem_mem[iv_waddr]   <= iv_wrem;
    end
    iv_tick_rd_q  <= iv_tick_mem[iv_raddr];
    iv_roll_rd_q  <= iv_roll_mem[iv_raddr];
    iv_users_rd_q <= iv_users_mem[iv_raddr];
    iv_rem_rd_q   <= iv_rem_mem[iv_raddr];
  end

  // Channel table port
  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_ref_mem[ch_waddr]   <= ch_wref;
      ch_start_mem[ch_waddr] <= ch_wstart;
      ch_roll_mem[ch_waddr]  <= ch_wroll;
      ch_iv_mem[ch_waddr]    <= ch_wiv;
      ch_smp_mem[ch_waddr]   <= ch_wsmp;
    end
    ch_ref_rd_q   <= ch_ref_mem[ch_raddr];
    ch_start_rd_q <= ch_start_mem[ch_raddr];
    ch_roll_rd_q  <= ch_roll_mem[ch_raddr];
    ch_iv_rd_q    <= ch_iv_mem[ch_raddr];
    ch_smp_rd_q   <= ch_smp_mem[ch_raddr];
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign sample_count_o = count_q;
  assign stepped_o      = stepped_q;

endmodule

### rtl/core/shared_interval_tick_timer.sv
// Top level of the shared interval tick timer.
//
//  Channel   Handshake            Payload
//  --------  -------------------  ----------------------------------------------------
//  command   start_i / busy_o     command_i, channel_id_i, interval_ms_i,
//                                 samples_per_tick_i
//  result    done_o (one cycle)   status_o, sample_count_o, stepped_o
//
// A ms tick walks interval table entries 1 to MAX_INTERVAL - 1, one entry per cycle,
// through its separate read and write ports. After reset a clearing pass zeroes the
// interval table, with busy_o high throughout. A two-item queue takes commands while
// the back end works; busy_o is high when it is full. Results come one per item, in
// order, and the receiver cannot stall them.
module shared_interval_tick_timer #(
  parameter int unsigned MAX_INTERVAL = sitt_pkg::DEF_MAX_INTERVAL,
  parameter int unsigned NUM_CHANNELS = sitt_pkg::DEF_NUM_CHANNELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [sitt_pkg::CMD_W-1:0]    command_i,
  input  logic [sitt_pkg::CH_W-1:0]     channel_id_i,
  input  logic [sitt_pkg::IVMS_W-1:0]   interval_ms_i,
  input  logic [sitt_pkg::SMP_W-1:0]    samples_per_tick_i,
  output logic                          done_o,
  output logic [sitt_pkg::STATUS_W-1:0] status_o,
  output logic [sitt_pkg::COUNT_W-1:0]  sample_count_o,
  output logic                          stepped_o
);

  logic            q_valid, pop, clearing;
  sitt_pkg::item_t q_item;

  // Command intake and queue
  sitt_front #(
    .MAX_INTERVAL(MAX_INTERVAL),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .command_i          (command_i),
    .channel_id_i       (channel_id_i),
    .interval_ms_i      (interval_ms_i),
    .samples_per_tick_i (samples_per_tick_i),
    .clearing_i         (clearing),
    .busy_o             (busy_o),
    .q_valid_o          (q_valid),
    .q_item_o           (q_item),
    .pop_i              (pop)
  );

  // Tables and execution
  sitt_back #(
    .MAX_INTERVAL(MAX_INTERVAL),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .clearing_o     (clearing),
    .done_o         (done_o),
    .status_o       (status_o),
    .sample_count_o (sample_count_o),
    .stepped_o      (stepped_o)
  );

endmodule

### dv/shared_interval_tick_timer_tb.sv
// Testbench for the shared interval tick timer: directed and random commands, scoreboard check.
`timescale 1ns / 100ps

module shared_interval_tick_timer_tb;
  import sitt_pkg::*;

  localparam int unsigned MAXI = DEF_MAX_INTERVAL;
  localparam int unsigned NCH  = DEF_NUM_CHANNELS;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                stepped;
  } timer_result_t;

  // Predicts timer results and compares them with what the block returns
  class tick_scoreboard;
    bit [TICK_W-1:0]  iv_tick  [MAXI];
    bit [6:0]         iv_users [MAXI];
    bit [31:0]        iv_rolls [MAXI];
    int unsigned      phase;
    bit [31:0]        ch_ref   [NCH];
    bit [31:0]        ch_start [NCH];
    bit [31:0]        ch_roll  [NCH];
    bit               ch_rdy   [NCH];
    bit [IVMS_W-1:0]  ch_iv    [NCH];
    bit [SMP_W-1:0]   ch_smp   [NCH];
    timer_result_t    pending_q[$];
    int unsigned      mismatches;
    int unsigned      n_ticks, n_stepped, n_not_due;

    function void advance_ms();
      phase++;
      for (int i = 1; i < MAXI; i++) begin
        if (iv_users[i] != 0 && (phase % i) == 0) begin
          iv_tick[i]++;
          if (iv_tick[i] == TICK_WRAP) begin
            iv_tick[i] = '0;
            iv_rolls[i]++;
          end
        end
      end
      if (phase >= MAXI) phase = 0;
    endfunction

    function void catch_up(int c);
      int v;
      v = ch_iv[c];
      if (ch_roll[c] < iv_rolls[v]) begin
        ch_roll[c]++;
        ch_ref[c]   = iv_tick[v];
        ch_start[c] = iv_tick[v];
      end
    endfunction

    function bit [31:0] step_channel(int c);
      longint unsigned prod;
      bit [31:0] diff;
      catch_up(c);
      diff = ch_ref[c] - ch_start[c];
      prod = 64'(ch_smp[c]) * 64'(diff);
      if (prod > 64'hFFFF_FFFF) begin
        ch_start[c] = ch_ref[c];
        prod = ch_smp[c];
      end
      ch_ref[c] = ch_ref[c] + 1;
      return prod[31:0];
    endfunction

    function void detach(int c);
      int v;
      v = ch_iv[c];
      if (iv_users[v] > 0) iv_users[v]--;
      if (iv_users[v] == 0) iv_tick[v] = '0;
      ch_rdy[c] = 1'b0;
    endfunction

    // Work out the result of one accepted item
    function void note_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                            logic [IVMS_W-1:0] iv, logic [SMP_W-1:0] smp);
      timer_result_t r;
      int c;
      c = ch;
      r.status = ST_OK;
      r.count = '0;
      r.stepped = 1'b0;
      case (cmd)
        CMD_TICK: begin
          advance_ms();
          n_ticks++;
        end
        CMD_INIT: begin
          if (iv == 0 || iv >= MAXI) r.status = ST_NOT_READY;
          else begin
            if (ch_rdy[c]) detach(c);
            iv_users[iv]++;
            ch_iv[c]    = iv;
            ch_smp[c]   = smp;
            ch_ref[c]   = iv_tick[iv];
            ch_start[c] = iv_tick[iv];
            ch_roll[c]  = iv_rolls[iv];
            ch_rdy[c]   = 1'b1;
          end
        end
        CMD_STEP: begin
          if (!ch_rdy[c]) r.status = ST_NOT_READY;
          else begin
            r.count = step_channel(c);
            r.stepped = 1'b1;
          end
        end
        CMD_CHECK: begin
          if (ch_rdy[c]) begin
            catch_up(c);
            if (iv_tick[ch_iv[c]] < ch_ref[c]) begin
              r.status = ST_NOT_DUE;
              n_not_due++;
            end else begin
              r.count = step_channel(c);
              r.stepped = 1'b1;
            end
          end
        end
        CMD_DESTROY: begin
          if (!ch_rdy[c]) r.status = ST_NOT_READY;
          else detach(c);
        end
        default: ;
      endcase
      if (r.stepped) n_stepped++;
      pending_q.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic stepped);
      timer_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d count=%0d stepped=%0b",
                   status, count, stepped);
        return;
      end
      e = pending_q.pop_front();
      if (status !== e.status || count !== e.count || stepped !== e.stepped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status exp %0d got %0d, count exp %0d got %0d, stepped exp %0b got %0b",
                   e.status, status, e.count, count, e.stepped, stepped);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [CH_W-1:0]     channel_id_i = '0;
  logic [IVMS_W-1:0]   interval_ms_i = '0;
  logic [SMP_W-1:0]    samples_per_tick_i = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  sample_count_o;
  logic                stepped_o;

  tick_scoreboard sb = new();
  int unsigned accepted = 0;

  shared_interval_tick_timer dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .channel_id_i, .interval_ms_i,
    .samples_per_tick_i, .done_o, .status_o, .sample_count_o, .stepped_o
  );

  always #2 clk_i = ~clk_i;

  // Accepted items and results, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      sb.note_item(command_i, channel_id_i, interval_ms_i, samples_per_tick_i);
      accepted++;
    end
    if (rst_ni && done_o) sb.check_result(status_o, sample_count_o, stepped_o);
  end

  // Drive one item after a random gap and wait until it is taken
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                           logic [IVMS_W-1:0] iv, logic [SMP_W-1:0] smp);
    int unsigned gap;
    int unsigned seen;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seen = accepted;
    start_i            <= 1'b1;
    command_i          <= cmd;
    channel_id_i       <= ch;
    interval_ms_i      <= iv;
    samples_per_tick_i <= smp;
    do @(negedge clk_i); while (accepted == seen);
  endtask

  // Random item, mostly aimed at a few channels on short intervals
  task automatic send_random();
    logic [CMD_W-1:0]  cmd;
    logic [CH_W-1:0]   ch;
    logic [IVMS_W-1:0] iv;
    logic [SMP_W-1:0]  smp;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25)      cmd = CMD_TICK;
    else if (sel < 42) cmd = CMD_INIT;
    else if (sel < 65) cmd = CMD_STEP;
    else if (sel < 88) cmd = CMD_CHECK;
    else if (sel < 96) cmd = CMD_DESTROY;
    else               cmd = CMD_DESTROY + 3'($urandom_range(1, 3));
    ch = ($urandom_range(0, 4) == 0) ? CH_W'($urandom) : CH_W'($urandom_range(0, 7));
    sel = $urandom_range(0, 19);
    if (sel < 14)      iv = IVMS_W'($urandom_range(1, 5));
    else if (sel < 18) iv = IVMS_W'($urandom_range(1, MAXI - 1));
    else if (sel < 19) iv = '0;
    else               iv = IVMS_W'($urandom_range(MAXI, 1023));
    smp = ($urandom_range(0, 3) == 0) ? SMP_W'($urandom) : SMP_W'($urandom_range(0, 300));
    send_item(cmd, ch, iv, smp);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edge values, each command, not-ready and not-due paths
    send_item(CMD_INIT,    6'd0,  10'd1,    16'hFFFF);
    send_item(CMD_STEP,    6'd0,  10'd0,    16'd0);
    send_item(CMD_CHECK,   6'd0,  10'd0,    16'd0);
    send_item(CMD_TICK,    6'd0,  10'd0,    16'd0);
    send_item(CMD_CHECK,   6'd0,  10'd0,    16'd0);
    send_item(CMD_INIT,    6'd63, 10'd999,  16'd0);
    send_item(CMD_INIT,    6'd2,  10'd0,    16'd5);
    send_item(CMD_INIT,    6'd3,  10'd1023, 16'd5);
    send_item(CMD_INIT,    6'd4,  10'd1000, 16'd5);
    send_item(CMD_STEP,    6'd5,  10'd0,    16'd0);
    send_item(CMD_CHECK,   6'd5,  10'd0,    16'd0);
    send_item(CMD_DESTROY, 6'd5,  10'd0,    16'd0);
    send_item(CMD_INIT,    6'd0,  10'd2,    16'd7);
    send_item(CMD_DESTROY, 6'd63, 10'd0,    16'd0);
    send_item(CMD_DESTROY + 3'd1, 6'd0, 10'd0, 16'd0);
    send_item(CMD_DESTROY + 3'd2, 6'd0, 10'd0, 16'd0);
    send_item(CMD_DESTROY + 3'd3, 6'd0, 10'd0, 16'd0);
    send_item(CMD_TICK,    6'd0,  10'd0,    16'd0);
    send_item(CMD_TICK,    6'd0,  10'd0,    16'd0);
    send_item(CMD_STEP,    6'd0,  10'd0,    16'd0);
    send_item(CMD_CHECK,   6'd0,  10'd0,    16'd0);
    send_item(CMD_INIT,    6'd1,  10'd512,  16'd1);
    send_item(CMD_DESTROY, 6'd0,  10'd0,    16'd0);
    send_item(CMD_DESTROY, 6'd1,  10'd0,    16'd0);

    repeat (520) send_random();
    start_i <= 1'b0;

    // Drain, then allow a full tick walk for anything late
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (MAXI + 20) @(negedge clk_i);

    $display("Run covered %0d items: %0d ms ticks, %0d stepped results, %0d not-due checks.",
             accepted, sb.n_ticks, sb.n_stepped, sb.n_not_due);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Mismatches: %0d, results missing: %0d", sb.mismatches, sb.pending_q.size());
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout waiting for the block");
    $display("Verification failed");
    $finish;
  end

endmodule
